/* rtl/rdc_pkg.sv */
`timescale 1ns / 1ps

package rdc_pkg;

	localparam int POS_W = 11;
	localparam int VAL_W = 12;
	localparam int CNT_W = 11;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_QUERY,
		ST_QDRAIN,
		ST_EMPTY,
		ST_LDRAIN
	} rdc_state_t;

	typedef struct packed {
		logic valid;
		logic add;
	} rdc_step_t;

	typedef struct packed {
		logic clearing;
		logic pipe_busy;
	} rdc_tstat_t;

endpackage

/* rtl/rdc_elem_ram.sv */
`timescale 1ns / 1ps

module rdc_elem_ram #(
	parameter int DEPTH = 1024,
	parameter int DW    = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/rdc_tally_unit.sv */
`timescale 1ns / 1ps

module rdc_tally_unit #(
	parameter int MAX_LENGTH  = 1024,
	parameter int VALUE_COUNT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rdc_pkg::rdc_step_t               step,
	input  logic [$clog2(VALUE_COUNT)-1:0]   elem_value,
	input  logic                             clear_total,
	output rdc_pkg::rdc_tstat_t              tstat,
	output logic [$clog2(MAX_LENGTH+1)-1:0]  total
);

	import rdc_pkg::*;

	localparam int VW = $clog2(VALUE_COUNT);
	localparam int PW = $clog2(MAX_LENGTH + 1);

	logic [PW-1:0] mem [VALUE_COUNT];
	logic [PW-1:0] rdata_q;

	logic          clr_q;
	logic [VW-1:0] clr_addr_q;

	rdc_step_t     op_s1, op_s2;
	logic [VW-1:0] v_s2;

	logic          fwd_q;
	logic [VW-1:0] fwd_addr_q;
	logic [PW-1:0] fwd_data_q;

	logic [PW-1:0] total_q;

	logic [PW-1:0] cur;
	logic [PW-1:0] upd;
	logic          upd_we;
	logic          we;
	logic [VW-1:0] waddr;
	logic [PW-1:0] wdata;

	// take the value written in the previous cycle; the RAM still returns the old one
	assign cur = (fwd_q && fwd_addr_q == v_s2) ? fwd_data_q : rdata_q;

	always_comb begin
		upd    = cur;
		upd_we = 1'b0;
		if (op_s2.valid) begin
			if (op_s2.add) begin
				upd    = cur + PW'(1);
				upd_we = 1'b1;
			end else if (cur != '0) begin
				upd    = cur - PW'(1);
				upd_we = 1'b1;
			end
		end
	end

	assign we    = clr_q | upd_we;
	assign waddr = clr_q ? clr_addr_q : v_s2;
	assign wdata = clr_q ? '0 : upd;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (op_s1.valid) begin
			rdata_q <= mem[elem_value];
		end
		v_s2       <= elem_value;
		fwd_addr_q <= v_s2;
		fwd_data_q <= upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			op_s1      <= '0;
			op_s2      <= '0;
			fwd_q      <= 1'b0;
			total_q    <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + VW'(1);
				if (clr_addr_q == VW'(VALUE_COUNT - 1)) begin
					clr_q <= 1'b0;
				end
			end
			op_s1 <= step;
			op_s2 <= op_s1;
			fwd_q <= upd_we;
			if (clear_total) begin
				total_q <= '0;
			end else if (op_s2.valid) begin
				if (op_s2.add && cur == '0) begin
					total_q <= total_q + PW'(1);
				end else if (!op_s2.add && cur == PW'(1) && total_q != '0) begin
					total_q <= total_q - PW'(1);
				end
			end
		end
	end

	assign tstat.clearing  = clr_q;
	assign tstat.pipe_busy = op_s1.valid | op_s2.valid;
	assign total           = total_q;

endmodule

/* rtl/rdc_ctrl.sv */
`timescale 1ns / 1ps

module rdc_ctrl #(
	parameter int MAX_LENGTH  = 1024,
	parameter int VALUE_COUNT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             kind,
	input  logic [rdc_pkg::POS_W-1:0]        load_position,
	input  logic [rdc_pkg::VAL_W-1:0]        load_value,
	input  logic [rdc_pkg::POS_W-1:0]        query_left,
	input  logic [rdc_pkg::POS_W-1:0]        query_right,
	input  rdc_pkg::rdc_tstat_t              tstat,
	input  logic [$clog2(MAX_LENGTH+1)-1:0]  total,
	output rdc_pkg::rdc_step_t               step,
	output logic [$clog2(MAX_LENGTH)-1:0]    elem_raddr,
	output logic                             elem_we,
	output logic [$clog2(MAX_LENGTH)-1:0]    elem_waddr,
	output logic [$clog2(VALUE_COUNT)-1:0]   elem_wdata,
	output logic                             clear_total,
	output logic                             done,
	output logic [rdc_pkg::CNT_W-1:0]        uniq_count,
	output logic                             bad_query
);

	import rdc_pkg::*;

	localparam int VW = $clog2(VALUE_COUNT);
	localparam int PW = $clog2(MAX_LENGTH + 1);
	localparam int AW = $clog2(MAX_LENGTH);

	localparam int     RED_S  = VAL_W + $clog2(VALUE_COUNT);
	localparam int     PROD_W = 2 * VAL_W + 2;
	localparam longint RED_M  = ((longint'(1) << RED_S) + longint'(VALUE_COUNT) - longint'(1))
	                            / longint'(VALUE_COUNT);

	rdc_state_t state_q, state_d;

	logic [PW-1:0] lp_q, rp_q, ql_q, qr_q;
	logic [PW-1:0] lp_d, rp_d;
	logic [PW-1:0] pos;
	logic          walk_done;

	logic [AW-1:0]     waddr_q;
	logic [VAL_W-1:0]  red_q;
	logic [VAL_W-1:0]  red_quo_q;
	logic              red_act_q;
	logic              red_sub_q;
	logic [PROD_W-1:0] red_prod;

	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             bad_q;

	logic take_query, take_load, q_bad, load_ok, emit;

	assign q_bad = (query_left == '0) || (query_right == '0) ||
	               (32'(query_left) > 32'(MAX_LENGTH)) ||
	               (32'(query_right) > 32'(MAX_LENGTH)) ||
	               (query_left > query_right);
	assign load_ok = (load_position != '0) && (32'(load_position) <= 32'(MAX_LENGTH));

	assign take_query = (state_q == ST_IDLE) && start && (kind == KIND_QUERY);
	assign take_load  = (state_q == ST_IDLE) && start && (kind == KIND_LOAD) && load_ok;

	// reduce modulo VALUE_COUNT by reciprocal multiplication: quotient, then remainder
	assign red_prod = PROD_W'(red_q) * PROD_W'(RED_M);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (!tstat.clearing) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (take_query && !q_bad) state_d = ST_QUERY;
				else if (take_load) state_d = ST_EMPTY;
			end
			ST_QUERY: begin
				if (walk_done) state_d = ST_QDRAIN;
			end
			ST_QDRAIN: begin
				if (!tstat.pipe_busy) state_d = ST_IDLE;
			end
			ST_EMPTY: begin
				if (walk_done) state_d = ST_LDRAIN;
			end
			ST_LDRAIN: begin
				if (!tstat.pipe_busy && !red_act_q && !red_sub_q) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		step        = '0;
		pos         = rp_q;
		lp_d        = lp_q;
		rp_d        = rp_q;
		walk_done   = 1'b0;
		elem_we     = 1'b0;
		clear_total = 1'b0;
		emit        = 1'b0;
		unique case (state_q)
			ST_QUERY: begin
				// grow right, grow left, shrink right, shrink left
				if (rp_q < qr_q) begin
					pos        = rp_q + PW'(1);
					rp_d       = pos;
					step.valid = 1'b1;
					step.add   = 1'b1;
				end else if (lp_q > ql_q) begin
					pos        = lp_q - PW'(1);
					lp_d       = pos;
					step.valid = 1'b1;
					step.add   = 1'b1;
				end else if (rp_q > qr_q) begin
					pos        = rp_q;
					rp_d       = rp_q - PW'(1);
					step.valid = 1'b1;
				end else if (lp_q < ql_q) begin
					pos        = lp_q;
					lp_d       = lp_q + PW'(1);
					step.valid = (lp_q != '0);
				end else begin
					walk_done = 1'b1;
				end
			end
			ST_QDRAIN: begin
				emit = !tstat.pipe_busy;
			end
			ST_EMPTY: begin
				// drop every element still held, right end first
				if (rp_q != '0 && rp_q >= lp_q) begin
					pos        = rp_q;
					rp_d       = rp_q - PW'(1);
					step.valid = 1'b1;
				end else begin
					lp_d      = '0;
					rp_d      = '0;
					walk_done = 1'b1;
				end
			end
			ST_LDRAIN: begin
				elem_we     = !tstat.pipe_busy && !red_act_q && !red_sub_q;
				clear_total = elem_we;
			end
			default: begin
			end
		endcase
	end

	assign elem_raddr = AW'(pos - PW'(1));
	assign elem_waddr = waddr_q;
	assign elem_wdata = VW'(red_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			lp_q      <= '0;
			rp_q      <= '0;
			red_act_q <= 1'b0;
			red_sub_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			lp_q      <= lp_d;
			rp_q      <= rp_d;
			red_act_q <= take_load;
			red_sub_q <= red_act_q;
			done_q    <= (take_query && q_bad) || emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take_query) begin
			ql_q <= PW'(query_left);
			qr_q <= PW'(query_right);
		end
		if (take_load) begin
			waddr_q <= AW'(load_position - POS_W'(1));
			red_q   <= load_value;
		end else if (red_sub_q) begin
			red_q <= red_q - VAL_W'(red_quo_q * VAL_W'(VALUE_COUNT));
		end
		if (red_act_q) begin
			red_quo_q <= VAL_W'(red_prod >> RED_S);
		end
		if (take_query && q_bad) begin
			cnt_q <= '0;
			bad_q <= 1'b1;
		end else if (emit) begin
			cnt_q <= CNT_W'(total);
			bad_q <= 1'b0;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign uniq_count = cnt_q;
	assign bad_query  = bad_q;

endmodule

/* rtl/range_distinct_count_window_top.sv */
`timescale 1ns / 1ps
// Query: the pointers are walked step by step (one tally read-modify-write each), then the pipe
// drains and the count is registered out. A rejected query answers in the next cycle.
// Load: the elements still in the window are dropped first (value reduction overlaps the walk).
// Throughput: one item at a time; busy drops in the cycle its result is out; no result can be stalled.
// After arst_n the tally memory is cleared while busy is held high.
module range_distinct_count_window_top #(
	parameter int MAX_LENGTH  = 1024,
	parameter int VALUE_COUNT = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      kind,
	input  logic [rdc_pkg::POS_W-1:0] load_position,
	input  logic [rdc_pkg::VAL_W-1:0] load_value,
	input  logic [rdc_pkg::POS_W-1:0] query_left,
	input  logic [rdc_pkg::POS_W-1:0] query_right,
	output logic                      done,
	output logic [rdc_pkg::CNT_W-1:0] uniq_count,
	output logic                      bad_query
);

	import rdc_pkg::*;

	localparam int VW = $clog2(VALUE_COUNT);
	localparam int PW = $clog2(MAX_LENGTH + 1);
	localparam int AW = $clog2(MAX_LENGTH);

	rdc_step_t  step;
	rdc_tstat_t tstat;

	logic [PW-1:0] total;
	logic [AW-1:0] elem_raddr, elem_waddr;
	logic [VW-1:0] elem_wdata, elem_rdata;
	logic          elem_we;
	logic          clear_total;

	rdc_ctrl #(
		.MAX_LENGTH (MAX_LENGTH),
		.VALUE_COUNT(VALUE_COUNT)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.load_position (load_position),
		.load_value    (load_value),
		.query_left    (query_left),
		.query_right   (query_right),
		.tstat         (tstat),
		.total         (total),
		.step          (step),
		.elem_raddr    (elem_raddr),
		.elem_we       (elem_we),
		.elem_waddr    (elem_waddr),
		.elem_wdata    (elem_wdata),
		.clear_total   (clear_total),
		.done          (done),
		.uniq_count    (uniq_count),
		.bad_query     (bad_query)
	);

	rdc_elem_ram #(
		.DEPTH(MAX_LENGTH),
		.DW   (VW)
	) u_elem_ram (
		.clk  (clk),
		.we   (elem_we),
		.waddr(elem_waddr),
		.wdata(elem_wdata),
		.re   (step.valid),
		.raddr(elem_raddr),
		.rdata(elem_rdata)
	);

	rdc_tally_unit #(
		.MAX_LENGTH (MAX_LENGTH),
		.VALUE_COUNT(VALUE_COUNT)
	) u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.elem_value (elem_rdata),
		.clear_total(clear_total),
		.tstat      (tstat),
		.total      (total)
	);

endmodule

/* sim/tb_range_distinct_count_window_top.sv */
`timescale 1ns / 1ps

module tb_range_distinct_count_window_top;
	import rdc_pkg::*;

	localparam int MAX_LEN     = 1024;
	localparam int VALUE_CNT   = 4096;
	localparam int N_ITEMS     = 1950;
	localparam int MAX_GAP     = 40;
	localparam int CYCLE_LIMIT = 3 * (VALUE_CNT + N_ITEMS * (2 * MAX_LEN + 8 + MAX_GAP));

	typedef struct {
		logic [CNT_W-1:0] count;
		logic             bad;
	} answer_t;

	class window_tally_board;
		logic [VAL_W-1:0] elem_store [MAX_LEN];
		logic [CNT_W-1:0] tally [VALUE_CNT];
		logic [POS_W-1:0] win_lo;
		logic [POS_W-1:0] win_hi;
		logic [CNT_W-1:0] distinct;
		answer_t          pending_answers [$];
		int               errors;

		function new();
			foreach (elem_store[i]) elem_store[i] = '0;
			foreach (tally[i]) tally[i] = '0;
			win_lo   = '0;
			win_hi   = '0;
			distinct = '0;
			errors   = 0;
		endfunction

		function void add_position(logic [POS_W-1:0] p);
			logic [VAL_W-1:0] v;
			v = elem_store[p - 1];
			tally[v] = tally[v] + 1'b1;
			if (tally[v] == 1) distinct = distinct + 1'b1;
		endfunction

		function void drop_position(logic [POS_W-1:0] p);
			logic [VAL_W-1:0] v;
			v = elem_store[p - 1];
			if (tally[v] == 0) return;
			tally[v] = tally[v] - 1'b1;
			if (tally[v] == 0 && distinct != 0) distinct = distinct - 1'b1;
		endfunction

		function void note_item(logic k, logic [POS_W-1:0] lp, logic [VAL_W-1:0] lv,
				logic [POS_W-1:0] ql, logic [POS_W-1:0] qr);
			answer_t          a;
			logic [POS_W-1:0] p;
			if (k == KIND_LOAD) begin
				if (lp >= 1 && lp <= MAX_LEN) begin
					// only values inside the window carry a tally
					for (p = (win_lo == 0) ? POS_W'(1) : win_lo; p <= win_hi; p++)
						tally[elem_store[p - 1]] = '0;
					distinct = '0;
					win_lo   = '0;
					win_hi   = '0;
					elem_store[lp - 1] = VAL_W'(lv % VALUE_CNT);
				end
				return;
			end
			if (ql < 1 || qr < 1 || ql > MAX_LEN || qr > MAX_LEN || ql > qr) begin
				a.count = '0;
				a.bad   = 1'b1;
			end else begin
				// grow before shrinking so the window never inverts
				while (win_hi < qr) begin
					win_hi = win_hi + 1'b1;
					add_position(win_hi);
				end
				while (win_lo > ql) begin
					win_lo = win_lo - 1'b1;
					add_position(win_lo);
				end
				while (win_hi > qr) begin
					drop_position(win_hi);
					win_hi = win_hi - 1'b1;
				end
				while (win_lo < ql) begin
					if (win_lo != 0) drop_position(win_lo);
					win_lo = win_lo + 1'b1;
				end
				a.count = distinct;
				a.bad   = 1'b0;
			end
			pending_answers.insert(pending_answers.size(), a);
		endfunction

		function void check_answer(logic [CNT_W-1:0] cnt, logic bad);
			answer_t a;
			if (pending_answers.size() == 0) begin
				$error("unexpected answer: uniq_count %0d bad_query %0b", cnt, bad);
				errors++;
				return;
			end
			a = pending_answers.pop_front();
			if (cnt !== a.count) begin
				$error("uniq_count: expected %0d, actual %0d", a.count, cnt);
				errors++;
			end
			if (bad !== a.bad) begin
				$error("bad_query: expected %0b, actual %0b", a.bad, bad);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_answers.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             kind;
	logic [POS_W-1:0] load_position;
	logic [VAL_W-1:0] load_value;
	logic [POS_W-1:0] query_left;
	logic [POS_W-1:0] query_right;
	logic             done;
	logic [CNT_W-1:0] uniq_count;
	logic             bad_query;

	window_tally_board sb = new();

	int cycles = 0;
	int burst_left;
	int filled;
	int cur_l;
	int cur_r;
	int counted;

	range_distinct_count_window_top #(
		.MAX_LENGTH (MAX_LEN),
		.VALUE_COUNT(VALUE_CNT)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.load_position (load_position),
		.load_value    (load_value),
		.query_left    (query_left),
		.query_right   (query_right),
		.done          (done),
		.uniq_count    (uniq_count),
		.bad_query     (bad_query)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("range_distinct_count_window_top verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_answer(uniq_count, bad_query);
	end

	task automatic idle_gap(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// hold start until the block takes the item
	task automatic send_item(input logic k, input logic [POS_W-1:0] lp,
			input logic [VAL_W-1:0] lv, input logic [POS_W-1:0] ql,
			input logic [POS_W-1:0] qr);
		if (burst_left == 0) begin
			idle_gap($urandom_range(1, MAX_GAP));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		start         <= 1'b1;
		kind          <= k;
		load_position <= lp;
		load_value    <= lv;
		query_left    <= ql;
		query_right   <= qr;
		do @(posedge clk); while (busy);
		sb.note_item(k, lp, lv, ql, qr);
	endtask

	task automatic send_load(input logic [POS_W-1:0] p, input logic [VAL_W-1:0] v);
		send_item(KIND_LOAD, p, v, POS_W'($urandom), POS_W'($urandom));
	endtask

	task automatic send_query(input logic [POS_W-1:0] l, input logic [POS_W-1:0] r);
		send_item(KIND_QUERY, POS_W'($urandom), VAL_W'($urandom), l, r);
		if (l >= 1 && l <= r && r <= MAX_LEN) begin
			cur_l = l;
			cur_r = r;
		end
	endtask

	task automatic pick_value(output logic [VAL_W-1:0] v);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) v = VAL_W'($urandom_range(0, 7));
		else if (r < 70) v = $urandom_range(0, 1) ? '1 : '0;
		else v = VAL_W'($urandom);
	endtask

	// good queries stay within the loaded prefix, so no unwritten entry is read
	task automatic pick_query(output logic [POS_W-1:0] l, output logic [POS_W-1:0] r);
		int c;
		int nl;
		int nr;
		int t;
		c = $urandom_range(0, 99);
		if (c < 8) begin
			case ($urandom_range(0, 4))
				0: begin
					nl = $urandom_range(2, filled);
					nr = $urandom_range(1, nl - 1);
				end
				1: begin
					nl = 0;
					nr = $urandom_range(0, 2047);
				end
				2: begin
					nl = $urandom_range(1, MAX_LEN);
					nr = 0;
				end
				3: begin
					nl = $urandom_range(MAX_LEN + 1, 2047);
					nr = $urandom_range(0, 2047);
				end
				default: begin
					nl = $urandom_range(1, MAX_LEN);
					nr = $urandom_range(MAX_LEN + 1, 2047);
				end
			endcase
		end else begin
			if (c < 20) begin
				nl = $urandom_range(1, filled);
				nr = $urandom_range(1, filled);
			end else if (c < 25) begin
				nl = 1;
				nr = filled;
			end else if (c < 30) begin
				nl = $urandom_range(1, filled);
				nr = nl;
			end else begin
				nl = cur_l + int'($urandom_range(0, 32)) - 16;
				nr = cur_r + int'($urandom_range(0, 32)) - 16;
			end
			if (nl < 1) nl = 1;
			if (nr < 1) nr = 1;
			if (nl > filled) nl = filled;
			if (nr > filled) nr = filled;
			if (nl > nr) begin
				t  = nl;
				nl = nr;
				nr = t;
			end
		end
		l = POS_W'(nl);
		r = POS_W'(nr);
	endtask

	initial begin
		logic [VAL_W-1:0] v;
		logic [POS_W-1:0] ql;
		logic [POS_W-1:0] qr;
		int               run;
		int               r;
		burst_left    = 0;
		arst_n        = 1'b0;
		start         = 1'b0;
		kind          = KIND_LOAD;
		load_position = '0;
		load_value    = '0;
		query_left    = '0;
		query_right   = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		send_load(POS_W'(1), '0);
		send_load(POS_W'(2), '1);
		send_load(POS_W'(3), '0);
		send_query(POS_W'(1), POS_W'(3));
		send_query(POS_W'(2), POS_W'(3));
		send_query(POS_W'(3), POS_W'(3));
		send_query(POS_W'(1), POS_W'(2));
		// out-of-range loads leave store and window alone
		send_load(POS_W'(0), 12'd5);
		send_load(POS_W'(MAX_LEN + 1), 12'd7);
		send_load('1, '1);
		send_query(POS_W'(1), POS_W'(1));
		send_query(POS_W'(3), POS_W'(1));
		send_query(POS_W'(0), POS_W'(2));
		send_query(POS_W'(1), POS_W'(0));
		send_query(POS_W'(1), POS_W'(MAX_LEN + 1));
		send_query('1, '1);
		send_query(POS_W'(MAX_LEN + 1), POS_W'(3));
		// rewrite empties the window
		send_load(POS_W'(2), '0);
		send_query(POS_W'(2), POS_W'(3));
		send_query(POS_W'(1), POS_W'(3));
		send_load(POS_W'(4), 12'hAAA);
		send_load(POS_W'(5), 12'h555);
		send_query(POS_W'(4), POS_W'(5));
		send_query(POS_W'(1), POS_W'(5));
		filled  = 5;
		counted = 0;

		while (counted < N_ITEMS) begin
			if (filled < MAX_LEN && $urandom_range(0, 1)) begin
				run = $urandom_range(8, 48);
				repeat (run) begin
					pick_value(v);
					r = $urandom_range(0, 99);
					if (r < 5) begin
						send_load($urandom_range(0, 1) ? POS_W'(0)
							: POS_W'($urandom_range(MAX_LEN + 1, 2047)), v);
					end else if (r < 15 || filled == MAX_LEN) begin
						send_load(POS_W'($urandom_range(1, filled)), v);
						counted++;
					end else begin
						filled++;
						send_load(POS_W'(filled), v);
						counted++;
					end
				end
			end else begin
				run = $urandom_range(4, 24);
				repeat (run) begin
					pick_query(ql, qr);
					send_query(ql, qr);
					counted++;
				end
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (2 * MAX_LEN + 64) @(posedge clk);
		if (sb.errors == 0)
			$display("range_distinct_count_window_top verification clean");
		else
			$display("range_distinct_count_window_top verification failed");
		$finish;
	end

endmodule
